/* sv/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue with reverse.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CMD_W      = 3;
  localparam int STAT_W     = 2;

  // stream payload widths, padded to whole bytes
  localparam int IN_BITS   = CMD_W + DATA_WIDTH;
  localparam int IN_TDW    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 3 * DATA_WIDTH + CNT_W + STAT_W;
  localparam int OUT_TDW   = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_REVERSE    = 3'd4,
    CMD_QUERY      = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DONE = 1'b1
  } fsm_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]     raddr;
  } mem_req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] popped;
    logic [DATA_WIDTH-1:0] front;
    logic [DATA_WIDTH-1:0] rear;
    logic [CNT_W-1:0]      occupancy;
    status_t               status;
  } result_t;

endpackage

/* sv/double_ended_queue_with_reverse.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_with_reverse
// Bounded deque of 32-bit signed words with push/pop at both ends, O(1)
// reverse and query; one result beat per command.
// ----------------------------------------------------------------------------
// In the accept cycle the pointers, count and direction flag update and the
// RAM is written (push) or read (pop, to refill the new end word); in the
// next cycle the registered RAM read returns, and the result is loaded into
// the output register as soon as that register is free. Because the single
// 64-entry store has registered reads, a new command is not accepted until
// the last result has been loaded. A finished result may wait in the output
// register while the next command is accepted and worked on; that command
// then holds in its completion state until the register frees up.
// Front and rear words are kept in registers, so every result reports them
// without further RAM reads. Pop on empty gives status 1, push on full gives
// status 2, and neither changes the queue. Command codes 6 and 7 act as query.
// ----------------------------------------------------------------------------
module double_ended_queue_with_reverse (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [dq_pkg::IN_TDW-1:0]  in_tdata,   // cmd[2:0], value[34:3], pad
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [dq_pkg::OUT_TDW-1:0] out_tdata   // popped_value[31:0],
                                                 // front_value[63:32],
                                                 // rear_value[95:64],
                                                 // occupancy[102:96],
                                                 // status[104:103], pad
);
  import dq_pkg::*;

  fsm_t                  state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_TDW-1:0]    out_data_r, out_data_nxt;

  logic                  in_fire;     // command beat accepted
  logic                  done;        // result moves to output register
  logic                  slot_free;   // output register free this cycle
  cmd_t                  cmd;
  logic [DATA_WIDTH-1:0] value;
  mem_req_t              mem_req;
  result_t               result;
  logic [DATA_WIDTH-1:0] rd_data;

  assign cmd       = cmd_t'(in_tdata[CMD_W-1:0]);
  assign value     = in_tdata[CMD_W +: DATA_WIDTH];
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // --- sequencer: next state ---
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --- sequencer: outputs ---
  always_comb begin
    in_tready = 1'b0;
    done      = 1'b0;
    unique case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_DONE:  done      = slot_free;
      default: begin
        in_tready = 1'b0;
        done      = 1'b0;
      end
    endcase
  end

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

  dq_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_fire),
    .cmd     (cmd),
    .value   (value),
    .rd_data (rd_data),
    .mem_req (mem_req),
    .result  (result)
  );

  // --- output register ---
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (done) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_TDW'({result.status, result.occupancy, result.rear,
                                result.front, result.popped});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_DONE && !in_tready)
    else $error("top: accepted beat did not enter completion");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_tvalid)
    else $error("top: completed result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !done)
    else $error("top: result overwrote a waiting beat");

endmodule

/* sv/dq_ram.sv */
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/dq_core.sv */
// ----------------------------------------------------------------------------
// dq_core
// End pointer, count, direction flag and cached end words; issues the RAM
// write for a push and the RAM read that refills an end word after a pop.
// ----------------------------------------------------------------------------
module dq_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  dq_pkg::cmd_t                   cmd,
  input  logic [dq_pkg::DATA_WIDTH-1:0]  value,
  input  logic [dq_pkg::DATA_WIDTH-1:0]  rd_data,
  output dq_pkg::mem_req_t               mem_req,
  output dq_pkg::result_t                result
);
  import dq_pkg::*;

  logic [ADDR_W-1:0]     lo_idx_r, lo_idx_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  rev_r, rev_nxt;
  logic [DATA_WIDTH-1:0] hi_word_r, hi_word_nxt;
  logic [DATA_WIDTH-1:0] lo_word_r, lo_word_nxt;
  logic [DATA_WIDTH-1:0] popped_r, popped_nxt;
  status_t               status_r, status_nxt;
  logic                  upd_hi_r, upd_hi_nxt;   // refill high end from RAM
  logic                  upd_lo_r, upd_lo_nxt;   // refill low end from RAM

  logic                  empty, full, to_high, from_high;
  logic [ADDR_W-1:0]     cnt_lo;
  logic [DATA_WIDTH-1:0] hi_eff, lo_eff;

  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign cnt_lo    = cnt_r[ADDR_W-1:0];
  assign to_high   = (cmd == CMD_PUSH_FRONT) ^ rev_r;
  assign from_high = (cmd == CMD_POP_FRONT) ^ rev_r;

  always_comb begin
    lo_idx_nxt    = lo_idx_r;
    cnt_nxt       = cnt_r;
    rev_nxt       = rev_r;
    hi_word_nxt   = hi_word_r;
    lo_word_nxt   = lo_word_r;
    popped_nxt    = popped_r;
    status_nxt    = status_r;
    upd_hi_nxt    = upd_hi_r;
    upd_lo_nxt    = upd_lo_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = ADDR_W'(lo_idx_r + cnt_lo);
    mem_req.wdata = value;
    mem_req.raddr = ADDR_W'(lo_idx_r + cnt_lo - ADDR_W'(2));

    if (accept) begin
      popped_nxt = '0;
      status_nxt = ST_OK;
      upd_hi_nxt = 1'b0;
      upd_lo_nxt = 1'b0;
      case (cmd) inside
        CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
          if (full) begin
            status_nxt = ST_PUSH_FULL;
          end else begin
            mem_req.we = 1'b1;
            cnt_nxt    = cnt_r + CNT_W'(1);
            if (to_high) begin
              hi_word_nxt = value;
              if (empty) begin
                lo_word_nxt = value;
              end
            end else begin
              lo_idx_nxt    = lo_idx_r - ADDR_W'(1);
              mem_req.waddr = lo_idx_r - ADDR_W'(1);
              lo_word_nxt   = value;
              if (empty) begin
                hi_word_nxt = value;
              end
            end
          end
        end
        CMD_POP_FRONT, CMD_POP_REAR: begin
          if (empty) begin
            status_nxt = ST_POP_EMPTY;
          end else begin
            cnt_nxt = cnt_r - CNT_W'(1);
            if (from_high) begin
              popped_nxt = hi_word_r;
              if (cnt_r == CNT_W'(2)) begin
                hi_word_nxt = lo_word_r;
              end else begin
                upd_hi_nxt = (cnt_r > CNT_W'(2));
              end
            end else begin
              popped_nxt    = lo_word_r;
              lo_idx_nxt    = lo_idx_r + ADDR_W'(1);
              mem_req.raddr = lo_idx_r + ADDR_W'(1);
              if (cnt_r == CNT_W'(2)) begin
                lo_word_nxt = hi_word_r;
              end else begin
                upd_lo_nxt = (cnt_r > CNT_W'(2));
              end
            end
          end
        end
        CMD_REVERSE: begin
          rev_nxt = ~rev_r;
        end
        default: begin
          // query and the unused codes change nothing
        end
      endcase
    end

    // refill read data is only valid the cycle after the pop; capture it
    // there so a stalled result keeps the right end word
    if (upd_hi_r || upd_lo_r) begin
      hi_word_nxt = hi_eff;
      lo_word_nxt = lo_eff;
      upd_hi_nxt  = 1'b0;
      upd_lo_nxt  = 1'b0;
    end
  end

  // end words as seen after the refill read lands
  assign hi_eff = upd_hi_r ? rd_data : hi_word_r;
  assign lo_eff = upd_lo_r ? rd_data : lo_word_r;

  always_comb begin
    result.popped    = popped_r;
    result.occupancy = cnt_r;
    result.status    = status_r;
    if (empty) begin
      result.front = '0;
      result.rear  = '0;
    end else begin
      result.front = rev_r ? lo_eff : hi_eff;
      result.rear  = rev_r ? hi_eff : lo_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_idx_r <= '0;
      cnt_r    <= '0;
      rev_r    <= 1'b0;
      upd_hi_r <= 1'b0;
      upd_lo_r <= 1'b0;
    end else begin
      lo_idx_r <= lo_idx_nxt;
      cnt_r    <= cnt_nxt;
      rev_r    <= rev_nxt;
      upd_hi_r <= upd_hi_nxt;
      upd_lo_r <= upd_lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_word_r <= hi_word_nxt;
    lo_word_r <= lo_word_nxt;
    popped_r  <= popped_nxt;
    status_r  <= status_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("dq_core: count above depth");

  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) && !full
    |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("dq_core: push did not grow count");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) && full
    |=> cnt_r == $past(cnt_r) && lo_idx_r == $past(lo_idx_r) && status_r == ST_PUSH_FULL)
    else $error("dq_core: refused push changed state");

  a_we_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> accept)
    else $error("dq_core: RAM write outside a command");

  a_one_refill: assert property (@(posedge clk) disable iff (!rst_n)
    !(upd_hi_r && upd_lo_r))
    else $error("dq_core: both ends pending refill");

endmodule
